@@ rtl/tccw_pkg.sv @@
// Shared types and constants for the text console cursor writer.
// No dependencies; imported by every module of the block.
`default_nettype none

package tccw_pkg;

    localparam int CHAR_W   = 8;
    localparam int COLOUR_W = 8;
    localparam int ENTRY_W  = CHAR_W + COLOUR_W;

    // Port widths of the result word
    localparam int ADDR_PORT_W = 11;
    localparam int ROW_PORT_W  = 5;
    localparam int COL_PORT_W  = 7;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PRINT,
        KIND_BACKSPACE,
        KIND_NEWLINE
    } t_kind;

    // Classified word passed from front to back
    typedef struct packed {
        t_kind             kind;
        logic [CHAR_W-1:0] char_code;
    } t_op;

    // Queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage : tccw_pkg

`default_nettype wire

@@ rtl/tccw_front.sv @@
// Front end: accepts character words and classifies them.
// Depends on tccw_pkg; feeds tccw_queue.
`default_nettype none

module tccw_front
    import tccw_pkg::*;
(
    input  wire logic              i_valid,
    input  wire logic [CHAR_W-1:0] i_char_code,
    output logic                   o_ready,
    input  wire t_qstat            i_qstat,
    output logic                   o_push,
    output t_op                    o_op
);

    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

    always_comb begin
        o_op.char_code = i_char_code;
        case (i_char_code)
            CH_BACKSPACE: begin
                o_op.kind = KIND_BACKSPACE;
            end
            CH_NEWLINE: begin
                o_op.kind = KIND_NEWLINE;
            end
            default: begin
                o_op.kind = KIND_PRINT;
            end
        endcase
    end

endmodule : tccw_front

`default_nettype wire

@@ rtl/tccw_queue.sv @@
// Short queue of classified words between front and back.
// Depends on tccw_pkg.
`default_nettype none

module tccw_queue
    import tccw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    input  wire logic i_pop,
    output t_op       o_op,
    output t_qstat    o_qstat
);

    t_op                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic               do_pop;

    assign do_pop         = i_pop && (r_count != '0);
    assign o_qstat.full   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_qstat.empty  = (r_count == '0);
    assign o_op           = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule : tccw_queue

`default_nettype wire

@@ rtl/tccw_back.sv @@
// Back end: cursor state, colour register, cell write and result register.
// Depends on tccw_pkg; pops words from tccw_queue.
`default_nettype none

module tccw_back
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int ROW_W   = $clog2(ROWS + 1),
    parameter int COL_W   = $clog2(COLUMNS),
    parameter int ADDR_W  = $clog2(ROWS * COLUMNS)
)(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [COLOUR_W-1:0] i_text_colour,
    input  wire t_op                 i_op,
    input  wire t_qstat              i_qstat,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic                     o_write_enable,
    output logic [ADDR_W-1:0]        o_cell_address,
    output logic [ENTRY_W-1:0]       o_cell_entry,
    output logic [ROW_W-1:0]         o_row,
    output logic [COL_W-1:0]         o_col,
    output logic                     o_off_screen
);

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_END  = ROW_W'(ROWS);

    logic [COLOUR_W-1:0] r_colour;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic                r_valid;
    logic                r_we, n_we;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [ENTRY_W-1:0]  r_entry, n_entry;
    logic                r_off, n_off;
    logic [ROW_W-1:0]    row_inc;
    logic                want_write;
    logic [CHAR_W-1:0]   wr_char;
    logic [ROW_W-1:0]    wr_row;
    logic [COL_W-1:0]    wr_col;

    // Advance when the result register is free or being taken
    assign o_pop   = !i_qstat.empty && (!r_valid || i_ready);
    assign row_inc = (r_row < ROW_END) ? r_row + 1'b1 : r_row;

    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        want_write = 1'b0;
        wr_char    = i_op.char_code;
        wr_row     = r_row;
        wr_col     = r_col;
        case (i_op.kind)
            KIND_BACKSPACE: begin
                if (r_col != '0) begin
                    n_col = r_col - 1'b1;
                end else if (r_row != '0) begin
                    n_row = r_row - 1'b1;
                    n_col = COL_LAST;
                end
                want_write = 1'b1;
                wr_char    = CH_BLANK;
                wr_row     = n_row;
                wr_col     = n_col;
            end
            KIND_NEWLINE: begin
                n_col = '0;
                n_row = row_inc;
            end
            default: begin
                want_write = 1'b1;
                if (r_col == COL_LAST) begin
                    n_col = '0;
                    n_row = row_inc;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        n_we    = 1'b0;
        n_off   = 1'b0;
        n_addr  = '0;
        n_entry = '0;
        if (want_write) begin
            if (wr_row < ROW_END) begin
                n_we    = 1'b1;
                n_addr  = ADDR_W'(wr_row) * ADDR_W'(COLUMNS) + ADDR_W'(wr_col);
                n_entry = {r_colour, wr_char};
            end else begin
                n_off = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colour <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_colour <= i_text_colour;
            end
            if (o_pop) begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded on each pop
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_we    <= n_we;
            r_addr  <= n_addr;
            r_entry <= n_entry;
            r_off   <= n_off;
        end
    end

    assign o_valid        = r_valid;
    assign o_write_enable = r_we;
    assign o_cell_address = r_addr;
    assign o_cell_entry   = r_entry;
    assign o_row          = r_row;
    assign o_col          = r_col;
    assign o_off_screen   = r_off;

endmodule : tccw_back

`default_nettype wire

@@ rtl/text_console_cursor_writer_top.sv @@
// Text console cursor writer: character words in, text-cell writes out.
// Input channel: i_valid / o_ready with i_char_code, one character per word.
// Output channel: o_valid / i_ready with one result word per character:
// write enable, cell address, cell entry (colour high byte, character low
// byte), cursor row and column after the character, and an off-screen flag.
// Colour register: written by i_cfg_wr_en / i_text_colour; the user must
// write it only while idle, not enforced by the block. Throughput: one
// character per cycle while i_ready is high, set by the single cursor
// update and cell-address multiply in the back end. A two-word queue sits
// between the front (classify) and the back (cursor update, result
// register). When the receiver stalls the result holds, the back stops and
// the queue fills; o_ready drops once it is full.
// Synchronous reset puts the cursor at row 0, column 0, colour 0, and
// empties the queue and the result register.
// Depends on tccw_pkg, tccw_front, tccw_queue and tccw_back.
`default_nettype none

module text_console_cursor_writer_top
    import tccw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [COLOUR_W-1:0]    i_text_colour,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [CHAR_W-1:0]      i_char_code,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic                        o_write_enable,
    output logic [ADDR_PORT_W-1:0]      o_cell_address,
    output logic [ENTRY_W-1:0]          o_cell_entry,
    output logic [ROW_PORT_W-1:0]       o_cursor_row_out,
    output logic [COL_PORT_W-1:0]       o_cursor_col_out,
    output logic                        o_off_screen
);

    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(ROWS * COLUMNS);

    t_qstat             w_qstat;
    t_op                w_front_op;
    t_op                w_queue_op;
    logic               w_push;
    logic               w_pop;
    logic [ADDR_W-1:0]  w_addr;
    logic [ROW_W-1:0]   w_row;
    logic [COL_W-1:0]   w_col;

    tccw_front u_front (
        .i_valid     (i_valid),
        .i_char_code (i_char_code),
        .o_ready     (o_ready),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_op        (w_front_op)
    );

    tccw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_front_op),
        .i_pop   (w_pop),
        .o_op    (w_queue_op),
        .o_qstat (w_qstat)
    );

    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ROW_W   (ROW_W),
        .COL_W   (COL_W),
        .ADDR_W  (ADDR_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_text_colour  (i_text_colour),
        .i_op           (w_queue_op),
        .i_qstat        (w_qstat),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_write_enable (o_write_enable),
        .o_cell_address (w_addr),
        .o_cell_entry   (o_cell_entry),
        .o_row          (w_row),
        .o_col          (w_col),
        .o_off_screen   (o_off_screen)
    );

    // Fit internal widths to the port widths
    assign o_cell_address   = ADDR_PORT_W'(w_addr);
    assign o_cursor_row_out = ROW_PORT_W'(w_row);
    assign o_cursor_col_out = COL_PORT_W'(w_col);

    a_we_off_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_write_enable && o_off_screen))
        else $error("write enable and off-screen flag both set");

    a_row_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_row <= ROW_W'(ROWS))
        else $error("cursor row beyond saturation");

    a_addr_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_enable) |-> (32'(w_addr) < 32'(ROWS * COLUMNS)))
        else $error("cell address off screen");

    a_empty_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && w_qstat.empty && !o_valid) |=> ##1 o_valid)
        else $error("result missing two cycles after accept into empty block");

endmodule : text_console_cursor_writer_top

`default_nettype wire

@@ dv/tb_text_console_cursor_writer_top.sv @@
// Testbench for text_console_cursor_writer_top: drives character words, predicts
// each cell write and cursor position, and checks every result word in order.
// Depends on tccw_pkg and the RTL of the block; needs no other file.
`timescale 1ns / 1ps

module tb_text_console_cursor_writer_top;
    import tccw_pkg::*;

    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int CLK_PERIOD     = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic                   we;
        logic [ADDR_PORT_W-1:0] addr;
        logic [ENTRY_W-1:0]     entry;
        logic [ROW_PORT_W-1:0]  row;
        logic [COL_PORT_W-1:0]  col;
        logic                   off;
    } t_cell_write;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [COLOUR_W-1:0]    i_text_colour = '0;
    logic                   i_valid       = 1'b0;
    logic [CHAR_W-1:0]      i_char_code   = '0;
    logic                   i_ready       = 1'b0;
    logic                   o_ready;
    logic                   o_valid;
    logic                   o_write_enable;
    logic [ADDR_PORT_W-1:0] o_cell_address;
    logic [ENTRY_W-1:0]     o_cell_entry;
    logic [ROW_PORT_W-1:0]  o_cursor_row_out;
    logic [COL_PORT_W-1:0]  o_cursor_col_out;
    logic                   o_off_screen;

    // Predictor state: cursor and colour register as the block should hold them
    int                  pred_row   = 0;
    int                  pred_col   = 0;
    logic [COLOUR_W-1:0] colour_reg = '0;

    t_cell_write pending_writes[$];
    t_cell_write expected_write;
    int          fail_count      = 0;
    int          sender_idle_pct = 0;
    int          ready_stall_pct = 0;
    int          quiet_cycles    = 0;

    text_console_cursor_writer_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_text_colour    (i_text_colour),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_char_code      (i_char_code),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_write_enable   (o_write_enable),
        .o_cell_address   (o_cell_address),
        .o_cell_entry     (o_cell_entry),
        .o_cursor_row_out (o_cursor_row_out),
        .o_cursor_col_out (o_cursor_col_out),
        .o_off_screen     (o_off_screen)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Cursor update and cell write for one character word
    function automatic t_cell_write predict_cell_write(input logic [CHAR_W-1:0] ch);
        t_cell_write       w;
        bit                do_write;
        logic [CHAR_W-1:0] wr_char;
        int                wr_row;
        int                wr_col;
        w        = '0;
        do_write = 1'b0;
        wr_char  = '0;
        wr_row   = 0;
        wr_col   = 0;
        if (ch == CH_BACKSPACE) begin
            if (pred_col > 0) begin
                pred_col--;
            end else if (pred_row > 0) begin
                pred_row--;
                pred_col = COLUMNS - 1;
            end
            do_write = 1'b1;
            wr_char  = CH_BLANK;
            wr_row   = pred_row;
            wr_col   = pred_col;
        end else if (ch == CH_NEWLINE) begin
            pred_col = 0;
            if (pred_row < ROWS) pred_row++;
        end else begin
            do_write = 1'b1;
            wr_char  = ch;
            wr_row   = pred_row;
            wr_col   = pred_col;
            pred_col++;
            if (pred_col >= COLUMNS) begin
                pred_col = 0;
                if (pred_row < ROWS) pred_row++;
            end
        end
        if (do_write) begin
            if (wr_row < ROWS) begin
                w.we    = 1'b1;
                w.addr  = ADDR_PORT_W'(wr_row * COLUMNS + wr_col);
                w.entry = {colour_reg, wr_char};
            end else begin
                w.off = 1'b1;
            end
        end
        w.row = ROW_PORT_W'(pred_row);
        w.col = COL_PORT_W'(pred_col);
        return w;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                     exp_val, act_val);
            fail_count++;
        end
    endtask

    // Predict on each accepted character, compare each accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) pending_writes.push_back(predict_cell_write(i_char_code));
            if (o_valid && i_ready) begin
                if (pending_writes.size() == 0) begin
                    $display("%0t: result word with none expected, expected none, actual %h",
                             $time, {o_write_enable, o_cell_address, o_cell_entry,
                             o_cursor_row_out, o_cursor_col_out, o_off_screen});
                    fail_count++;
                end else begin
                    expected_write = pending_writes.pop_front();
                    check_field("write_enable", expected_write.we, o_write_enable);
                    check_field("cell_address", expected_write.addr, o_cell_address);
                    check_field("cell_entry", expected_write.entry, o_cell_entry);
                    check_field("cursor_row", expected_write.row, o_cursor_row_out);
                    check_field("cursor_col", expected_write.col, o_cursor_col_out);
                    check_field("off_screen", expected_write.off, o_off_screen);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // Offer one character word; return at the falling edge after it is taken
    task automatic send_char(input logic [CHAR_W-1:0] ch);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= ch;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_writes.size() != 0) @(negedge i_clk);
        // let the pipeline settle
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_colour(input logic [COLOUR_W-1:0] colour);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_text_colour <= colour;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        colour_reg = colour;
    endtask

    task automatic set_idling(input int sender_pct, input int stall_pct);
        sender_idle_pct = sender_pct;
        ready_stall_pct = stall_pct;
    endtask

    // Colour at reset, backspace at the top-left corner
    task automatic test_reset_state();
        send_char(8'h41);
        send_char(CH_BACKSPACE);
        send_char(CH_BACKSPACE);
    endtask

    task automatic test_char_extremes();
        write_colour(8'hFF);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h7F);
        send_char(8'h80);
        send_char(CH_BLANK);
        send_char(8'h09);
        send_char(8'h0B);
        send_char(8'h07);
    endtask

    // Backspace across a row start, then a print that wraps at the row end
    task automatic test_row_wrap();
        write_colour(8'h00);
        send_char(CH_NEWLINE);
        send_char(CH_BACKSPACE);
        send_char(8'h5A);
        send_char(CH_NEWLINE);
        send_char(CH_BACKSPACE);
        send_char(CH_NEWLINE);
    endtask

    task automatic test_below_screen();
        while (pred_row < ROWS) send_char(CH_NEWLINE);
        send_char(CH_NEWLINE);      // row holds at ROWS
        send_char(8'h78);           // suppressed write
        send_char(CH_BACKSPACE);    // suppressed blank
        send_char(CH_BACKSPACE);    // back onto the last screen row
        send_char(8'h79);           // wraps below the screen
    endtask

    task automatic run_char_stream(input int count, input int nl_pct, input int bs_pct);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < nl_pct) begin
                send_char(CH_NEWLINE);
            end else if (pick < nl_pct + bs_pct) begin
                send_char(CH_BACKSPACE);
            end else begin
                send_char(CHAR_W'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_random_top(); 
        set_idling(0, 0);
        write_colour(8'h5A);
        run_char_stream(300, 2, 20);
    endtask

    task automatic test_random_descend();
        set_idling(48, 0);
        write_colour(8'hF0);
        run_char_stream(300, 4, 10);
    endtask

    task automatic test_random_below();
        set_idling(0, 48);
        write_colour(8'h0F);
        test_below_screen();
        // hold the sender until every result is in
        wait_drained();
        run_char_stream(300, 5, 30);
    endtask

    task automatic test_random_climb();
        set_idling(27, 27);
        write_colour(COLOUR_W'($urandom_range(255)));
        run_char_stream(300, 1, 85);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_char_extremes();
        test_row_wrap();
        test_random_top();
        test_random_descend();
        test_random_below();
        test_random_climb();
        wait_drained();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
